FILE: src/gb3_pkg.sv
package gb3_pkg;

  localparam int ChanW        = 8;
  localparam int NumChan      = 3;
  localparam int ColW         = 11;
  localparam int RowW         = 16;
  localparam int LineWidthW   = 12;
  localparam int FrameHeightW = 16;
  localparam int WeightW      = 16;
  localparam int SumW         = 10;
  localparam int FracBits     = 16;
  localparam int ProdW        = SumW + WeightW;
  localparam int AccW         = ProdW + 2;
  localparam int QDepth       = 4;
  localparam int QPtrW        = 2;
  localparam int AddrW        = 5;
  localparam int DataW        = 32;

  localparam logic [ChanW-1:0]        OutMax             = 8'd255;
  localparam logic [LineWidthW-1:0]   LineWidthReset     = 12'd640;
  localparam logic [FrameHeightW-1:0] FrameHeightReset   = 16'd480;
  localparam logic [WeightW-1:0]      WeightCenterReset  = 16'd16384;
  localparam logic [WeightW-1:0]      WeightEdgeReset    = 16'd8192;
  localparam logic [WeightW-1:0]      WeightCornerReset  = 16'd4096;

  typedef enum logic [2:0] {
    RegLineWidth    = 3'd0,
    RegFrameHeight  = 3'd1,
    RegWeightCenter = 3'd2,
    RegWeightEdge   = 3'd3,
    RegWeightCorner = 3'd4
  } gb3_reg_e;

  // channel 2 is red, 1 green, 0 blue
  typedef logic [NumChan-1:0][ChanW-1:0] gb3_pixel_t;

  typedef struct packed {
    logic own;
    logic right;
    logic inner;
    logic left;
  } gb3_emit_t;

  typedef struct packed {
    logic [LineWidthW-1:0]   line_width;
    logic [FrameHeightW-1:0] frame_height;
  } gb3_geom_t;

  typedef struct packed {
    logic [WeightW-1:0] w_center;
    logic [WeightW-1:0] w_side;
    logic [WeightW-1:0] w_corner;
  } gb3_weights_t;

  typedef struct packed {
    logic [ColW-1:0]                 col;
    logic [RowW-1:0]                 row;
    gb3_emit_t                       emit;
    gb3_pixel_t                      center;
    logic [NumChan-1:0][SumW-1:0]    side_sum;
    logic [NumChan-1:0][SumW-1:0]    corner_sum;
  } gb3_entry_t;

endpackage

FILE: src/gb3_front.sv
module gb3_front #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gb3_pkg::gb3_geom_t    geom_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  gb3_pkg::gb3_pixel_t   pixel_i,
  output logic                  push_o,
  output gb3_pkg::gb3_entry_t   entry_o,
  input  logic                  full_i
);

  localparam int ColCntW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;

  gb3_pkg::gb3_pixel_t upper_mem  [MAX_WIDTH];
  gb3_pkg::gb3_pixel_t middle_mem [MAX_WIDTH];

  logic [ColCntW-1:0]              col_q, col_d, col_cur, wlast;
  logic [gb3_pkg::RowW-1:0]        row_q, row_d, row_cur, hlast;
  logic                            accept, s1_fire;

  logic                            s1_valid_q;
  logic [ColCntW-1:0]              s1_col_q;
  logic [gb3_pkg::RowW-1:0]        s1_row_q;
  gb3_pkg::gb3_emit_t              s1_emit_q, emit_d;
  gb3_pkg::gb3_pixel_t             s1_low_q, up_rd_q, mid_rd_q;
  gb3_pkg::gb3_pixel_t             win_q [6];

  // effective last column and last row
  always_comb begin
    if (geom_i.line_width < 12'd3) begin
      wlast = ColCntW'(2);
    end else if (32'(geom_i.line_width) > MAX_WIDTH) begin
      wlast = ColCntW'(MAX_WIDTH - 1);
    end else begin
      wlast = ColCntW'(geom_i.line_width - 12'd1);
    end
    if (geom_i.frame_height < 16'd3) begin
      hlast = 16'd2;
    end else begin
      hlast = geom_i.frame_height - 16'd1;
    end
    col_cur = (col_q > wlast) ? wlast : col_q;
    row_cur = (row_q > hlast) ? hlast : row_q;
  end

  always_comb begin
    emit_d.left  = (row_cur >= 16'd2) && (col_cur == '0);
    emit_d.inner = (row_cur >= 16'd2) && (col_cur >= ColCntW'(2));
    emit_d.right = (row_cur >= 16'd2) && (col_cur == wlast);
    emit_d.own   = (row_cur == '0) || (row_cur == hlast);
    if (col_cur == wlast) begin
      col_d = '0;
      row_d = (row_cur == hlast) ? '0 : row_cur + 16'd1;
    end else begin
      col_d = col_cur + ColCntW'(1);
      row_d = row_cur;
    end
  end

  assign s1_fire    = s1_valid_q && ((s1_emit_q == '0) || !full_i);
  assign push_o     = s1_valid_q && (s1_emit_q != '0) && !full_i;
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        win_q[3] <= win_q[0];
        win_q[4] <= win_q[1];
        win_q[5] <= win_q[2];
        win_q[0] <= up_rd_q;
        win_q[1] <= mid_rd_q;
        win_q[2] <= s1_low_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q  <= col_cur;
      s1_row_q  <= row_cur;
      s1_emit_q <= emit_d;
      s1_low_q  <= pixel_i;
      up_rd_q   <= upper_mem[col_cur];
      mid_rd_q  <= middle_mem[col_cur];
    end
    if (s1_fire) begin
      upper_mem[s1_col_q]  <= mid_rd_q;
      middle_mem[s1_col_q] <= s1_low_q;
    end
  end

  always_comb begin
    entry_o.col    = gb3_pkg::ColW'(s1_col_q);
    entry_o.row    = s1_row_q;
    entry_o.emit   = s1_emit_q;
    entry_o.center = win_q[1];
    for (int ch = 0; ch < gb3_pkg::NumChan; ch++) begin
      entry_o.side_sum[ch] = gb3_pkg::SumW'(win_q[0][ch]) + gb3_pkg::SumW'(win_q[4][ch])
                           + gb3_pkg::SumW'(mid_rd_q[ch]) + gb3_pkg::SumW'(win_q[2][ch]);
      entry_o.corner_sum[ch] = gb3_pkg::SumW'(win_q[3][ch]) + gb3_pkg::SumW'(up_rd_q[ch])
                             + gb3_pkg::SumW'(win_q[5][ch]) + gb3_pkg::SumW'(s1_low_q[ch]);
    end
  end

endmodule

FILE: src/gb3_fifo.sv
module gb3_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  gb3_pkg::gb3_entry_t  din_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output gb3_pkg::gb3_entry_t  dout_o,
  output logic                 empty_o
);

  gb3_pkg::gb3_entry_t          mem_q [gb3_pkg::QDepth];
  logic [gb3_pkg::QPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [gb3_pkg::QPtrW:0]      count_q, count_d;

  assign full_o  = (count_q == (gb3_pkg::QPtrW + 1)'(gb3_pkg::QDepth));
  assign empty_o = (count_q == '0);
  assign dout_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= din_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue read while empty");

endmodule

FILE: src/gb3_back.sv
module gb3_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gb3_pkg::gb3_weights_t      weights_i,
  input  gb3_pkg::gb3_entry_t        entry_i,
  input  logic                       empty_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [gb3_pkg::ColW-1:0]   out_col_o,
  output logic [gb3_pkg::RowW-1:0]   out_row_o,
  output gb3_pkg::gb3_pixel_t        out_pixel_o,
  output logic                       out_last_o
);

  localparam int CenterProdW = gb3_pkg::ChanW + gb3_pkg::WeightW;

  // multiply stage
  logic                                          b1_valid_q;
  logic [gb3_pkg::ColW-1:0]                      b1_col_q;
  logic [gb3_pkg::RowW-1:0]                      b1_row_q;
  gb3_pkg::gb3_emit_t                            b1_emit_q;
  logic [gb3_pkg::NumChan-1:0][CenterProdW-1:0]  b1_center_q;
  logic [gb3_pkg::NumChan-1:0][gb3_pkg::ProdW-1:0] b1_side_q, b1_corner_q;

  // sum/saturate stage, serialized into results
  logic                       b2_valid_q;
  logic [gb3_pkg::ColW-1:0]   b2_col_q;
  logic [gb3_pkg::RowW-1:0]   b2_row_q;
  gb3_pkg::gb3_emit_t         b2_emit_q;
  gb3_pkg::gb3_pixel_t        b2_pixel_q, pixel_d;

  logic                       out_valid_q;
  logic [gb3_pkg::ColW-1:0]   out_col_q, col_sel;
  logic [gb3_pkg::RowW-1:0]   out_row_q, row_sel;
  gb3_pkg::gb3_pixel_t        out_pixel_q, pixel_sel;
  logic                       out_last_q;

  gb3_pkg::gb3_emit_t         sel, rest;
  logic                       load, last, b1_take, b2_take;
  logic [gb3_pkg::AccW-1:0]   acc;
  logic [gb3_pkg::AccW-gb3_pkg::FracBits-1:0] scaled;

  assign load    = b2_valid_q && (!out_valid_q || out_ready_i);
  assign b2_take = !b2_valid_q || (load && last);
  assign b1_take = !b1_valid_q || b2_take;
  assign pop_o   = !empty_i && b1_take;

  always_comb begin
    for (int ch = 0; ch < gb3_pkg::NumChan; ch++) begin
      acc = gb3_pkg::AccW'(b1_center_q[ch]) + gb3_pkg::AccW'(b1_side_q[ch])
          + gb3_pkg::AccW'(b1_corner_q[ch]);
      scaled = acc[gb3_pkg::AccW-1:gb3_pkg::FracBits];
      if (scaled > (gb3_pkg::AccW - gb3_pkg::FracBits)'(gb3_pkg::OutMax)) begin
        pixel_d[ch] = gb3_pkg::OutMax;
      end else begin
        pixel_d[ch] = scaled[gb3_pkg::ChanW-1:0];
      end
    end
  end

  // pick results in order: left border, interior, right border, own pixel
  always_comb begin
    sel       = '0;
    col_sel   = b2_col_q;
    row_sel   = b2_row_q;
    pixel_sel = '0;
    if (b2_emit_q.left) begin
      sel.left = 1'b1;
      col_sel  = '0;
      row_sel  = b2_row_q - 1'b1;
    end else if (b2_emit_q.inner) begin
      sel.inner = 1'b1;
      col_sel   = b2_col_q - 1'b1;
      row_sel   = b2_row_q - 1'b1;
      pixel_sel = b2_pixel_q;
    end else if (b2_emit_q.right) begin
      sel.right = 1'b1;
      row_sel   = b2_row_q - 1'b1;
    end else begin
      sel.own = 1'b1;
    end
    rest = b2_emit_q & ~sel;
    last = (rest == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      b2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (b1_take) begin
        b1_valid_q <= pop_o;
      end
      if (b2_take) begin
        b2_valid_q <= b1_valid_q;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b1_col_q  <= entry_i.col;
      b1_row_q  <= entry_i.row;
      b1_emit_q <= entry_i.emit;
      for (int ch = 0; ch < gb3_pkg::NumChan; ch++) begin
        b1_center_q[ch] <= CenterProdW'(entry_i.center[ch]) * CenterProdW'(weights_i.w_center);
        b1_side_q[ch]   <= gb3_pkg::ProdW'(entry_i.side_sum[ch])
                         * gb3_pkg::ProdW'(weights_i.w_side);
        b1_corner_q[ch] <= gb3_pkg::ProdW'(entry_i.corner_sum[ch])
                         * gb3_pkg::ProdW'(weights_i.w_corner);
      end
    end
    if (b2_take && b1_valid_q) begin
      b2_col_q   <= b1_col_q;
      b2_row_q   <= b1_row_q;
      b2_emit_q  <= b1_emit_q;
      b2_pixel_q <= pixel_d;
    end else if (load) begin
      b2_emit_q <= rest;
    end
    if (load) begin
      out_col_q   <= col_sel;
      out_row_q   <= row_sel;
      out_pixel_q <= pixel_sel;
      out_last_q  <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_col_o   = out_col_q;
  assign out_row_o   = out_row_q;
  assign out_pixel_o = out_pixel_q;
  assign out_last_o  = out_last_q;

  a_b2_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b2_valid_q |-> (b2_emit_q != '0)) else $error("serializer holds an item with no results");

  a_b2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b2_valid_q && out_valid_q && !out_ready_i) |=> (b2_valid_q && $stable(b2_emit_q)))
    else $error("serializer advanced while output stalled");

endmodule

FILE: src/gaussian_blur_3x3_rgb_unit.sv
// 3x3 Gaussian blur over an RGB raster stream.
// Input channel: in_valid_i/in_ready_o with red_in_i, green_in_i, blue_in_i, one
// pixel per transaction in raster order. Output channel: out_valid_o/out_ready_i
// with column, row, the three filtered channels and last_of_run_o, which marks
// the final result caused by one input pixel (each pixel causes zero to three).
// Interior pixels get the weighted 3x3 sum (Q0.16 weights, truncated, clipped
// to 255); border pixels come out as zero. Every frame gives width*height results.
// A pixel's results pass the line store read register, the queue, the multiply
// stage, the sum/saturate stage and the output register, in that order.
// Throughput: one pixel per cycle while each pixel causes at most one result and
// the receiver does not stall; the output port moves one result per cycle, so row
// ends and the last row, which cause up to three results per pixel, drain slower.
// A 4-entry queue parts the pixel front end from the filter back end; when the
// receiver stalls, results hold in the output register, the queue fills and
// then in_ready_o drops. The line stores are not cleared.
// Reset: counters at row 0 column 0, window zero, registers at their defaults
// (width 640, height 480, weights 16384/8192/4096). Write registers over the APB
// port only while the stream is idle; the block itself does not enforce this.
module gaussian_blur_3x3_rgb_unit #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gb3_pkg::AddrW-1:0]     paddr,
  input  logic [gb3_pkg::DataW-1:0]     pwdata,
  output logic [gb3_pkg::DataW-1:0]     prdata,
  output logic                          pready,
  // pixel input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [gb3_pkg::ChanW-1:0]     red_in_i,
  input  logic [gb3_pkg::ChanW-1:0]     green_in_i,
  input  logic [gb3_pkg::ChanW-1:0]     blue_in_i,
  // filtered output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [gb3_pkg::ColW-1:0]      out_col_o,
  output logic [gb3_pkg::RowW-1:0]      out_row_o,
  output logic [gb3_pkg::ChanW-1:0]     red_out_o,
  output logic [gb3_pkg::ChanW-1:0]     green_out_o,
  output logic [gb3_pkg::ChanW-1:0]     blue_out_o,
  output logic                          last_of_run_o
);

  logic [gb3_pkg::LineWidthW-1:0]   line_width_q;
  logic [gb3_pkg::FrameHeightW-1:0] frame_height_q;
  logic [gb3_pkg::WeightW-1:0]      weight_center_q, weight_edge_q, weight_corner_q;

  gb3_pkg::gb3_reg_e      reg_sel;
  logic                   cfg_write;
  gb3_pkg::gb3_geom_t     geom;
  gb3_pkg::gb3_weights_t  weights;
  gb3_pkg::gb3_pixel_t    pixel_in, pixel_out;
  gb3_pkg::gb3_entry_t    push_entry, pop_entry;
  logic                   push, pop, full, empty;

  // Register file: word address selects the register, byte offset ignored.
  assign pready    = 1'b1;
  assign reg_sel   = gb3_pkg::gb3_reg_e'(paddr[gb3_pkg::AddrW-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q    <= gb3_pkg::LineWidthReset;
      frame_height_q  <= gb3_pkg::FrameHeightReset;
      weight_center_q <= gb3_pkg::WeightCenterReset;
      weight_edge_q   <= gb3_pkg::WeightEdgeReset;
      weight_corner_q <= gb3_pkg::WeightCornerReset;
    end else if (cfg_write) begin
      case (reg_sel)
        gb3_pkg::RegLineWidth:    line_width_q    <= pwdata[gb3_pkg::LineWidthW-1:0];
        gb3_pkg::RegFrameHeight:  frame_height_q  <= pwdata[gb3_pkg::FrameHeightW-1:0];
        gb3_pkg::RegWeightCenter: weight_center_q <= pwdata[gb3_pkg::WeightW-1:0];
        gb3_pkg::RegWeightEdge:   weight_edge_q   <= pwdata[gb3_pkg::WeightW-1:0];
        gb3_pkg::RegWeightCorner: weight_corner_q <= pwdata[gb3_pkg::WeightW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      gb3_pkg::RegLineWidth:    prdata = gb3_pkg::DataW'(line_width_q);
      gb3_pkg::RegFrameHeight:  prdata = gb3_pkg::DataW'(frame_height_q);
      gb3_pkg::RegWeightCenter: prdata = gb3_pkg::DataW'(weight_center_q);
      gb3_pkg::RegWeightEdge:   prdata = gb3_pkg::DataW'(weight_edge_q);
      gb3_pkg::RegWeightCorner: prdata = gb3_pkg::DataW'(weight_corner_q);
      default:                  prdata = '0;
    endcase
  end

  assign geom.line_width   = line_width_q;
  assign geom.frame_height = frame_height_q;
  assign weights.w_center  = weight_center_q;
  assign weights.w_side    = weight_edge_q;
  assign weights.w_corner  = weight_corner_q;

  assign pixel_in = {red_in_i, green_in_i, blue_in_i};

  // Front end: raster counters, line stores, window, result classification.
  gb3_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .geom_i     (geom),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .pixel_i    (pixel_in),
    .push_o     (push),
    .entry_o    (push_entry),
    .full_i     (full)
  );

  // Decouple the two halves so either side may stall on its own.
  gb3_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .dout_o  (pop_entry),
    .empty_o (empty)
  );

  // Back end: weighted sums, saturation, and one result per output transaction.
  gb3_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .weights_i   (weights),
    .entry_i     (pop_entry),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_col_o   (out_col_o),
    .out_row_o   (out_row_o),
    .out_pixel_o (pixel_out),
    .out_last_o  (last_of_run_o)
  );

  assign red_out_o   = pixel_out[2];
  assign green_out_o = pixel_out[1];
  assign blue_out_o  = pixel_out[0];

endmodule
